### design/kvi_pkg.sv
// Package for the keyframe vector interpolator.
// Shared constants, command codes and the sequencer state type.
// No dependencies.
package kvi_pkg;

  localparam int MAX_KEYS = 16;
  localparam int KEY_W    = $clog2(MAX_KEYS);
  localparam int CNT_W    = $clog2(MAX_KEYS + 1);
  localparam int FRAC_W   = 17;
  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  localparam logic REG_KEY_COUNT = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RD_LAST,
    ST_RD_NEXT,
    ST_LOAD,
    ST_DIVIDE,
    ST_SM1,
    ST_SM2,
    ST_SM3,
    ST_BL1,
    ST_BL2,
    ST_DONE
  } kvi_state_t;

endpackage

### design/kvi_divider.sv
// Restoring divider for the segment fraction, one quotient bit a cycle.
// Saturates to 1.0 when the dividend is not below the divisor.
// Depends on kvi_pkg.
module kvi_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [31:0]               dividend,
  input  logic [31:0]               divisor,
  output logic                      done,
  output logic [kvi_pkg::FRAC_W-1:0] quotient
);
  import kvi_pkg::*;

  logic        busy;
  logic [3:0]  count;
  logic [31:0] rem;
  logic [32:0] rem2;
  logic        bit_ge;

  assign rem2   = {rem, 1'b0};
  assign bit_ge = rem2 >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        count <= '0;
        if (dividend >= divisor) begin
          quotient <= FRAC_ONE;
          done <= 1'b1;
        end else begin
          rem <= dividend;
          quotient <= '0;
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem <= bit_ge ? 32'(rem2 - {1'b0, divisor}) : rem2[31:0];
        quotient <= {quotient[FRAC_W-2:0], bit_ge};
        count <= count + 4'd1;
        if (count == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### design/kvi_blend_lane.sv
// One component lane: out = a + floor((b - a) * f / 2^16).
// Two register stages: product, then sum. Depends on kvi_pkg.
module kvi_blend_lane (
  input  logic                       clk,
  input  logic signed [31:0]         a,
  input  logic signed [31:0]         b,
  input  logic [kvi_pkg::FRAC_W-1:0] f,
  output logic signed [31:0]         result
);
  import kvi_pkg::*;

  logic signed [32:0] diff;
  logic signed [50:0] diff_w;
  logic signed [50:0] f_w;
  logic signed [50:0] prod;

  assign diff   = {b[31], b} - {a[31], a};
  assign diff_w = 51'(diff);
  assign f_w    = 51'(signed'({1'b0, f}));

  always_ff @(posedge clk) begin
    prod   <= diff_w * f_w;
    // Only the low 32 bits of the arithmetic shift reach the wrapped sum.
    result <= a + signed'(prod[47:16]);
  end

endmodule

### design/keyframe_vector_interpolator_core.sv
// Top level of the keyframe vector interpolator: keyframe store, compare
// lanes with priority merge, sequencer, divider, smoothstep and blend lanes.
// Depends on kvi_pkg, kvi_divider and kvi_blend_lane.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    command .. sample_time
//   out      output     out_valid / out_stall  out_x, out_y, out_z, segment_start
//   cfg      input      APB psel/penable       key_count at address 0
//
// A write transfer does not raise in_stall. An evaluate keeps it high through
// scan, reads, load, any division (one fraction bit a cycle), smoothstep if
// selected, blend, and longer while a previous result waits in the output register.
// Reset clears the sequencer, key_count (to 1) and the output valid flag;
// the keyframe store holds no reset value. A stalled result sits in the
// output register while the next transfer is taken in.
module keyframe_vector_interpolator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [3:0]  entry_index,
  input  logic [31:0] key_time,
  input  logic [31:0] key_value_x,
  input  logic [31:0] key_value_y,
  input  logic [31:0] key_value_z,
  input  logic        interp_mode,
  input  logic [31:0] sample_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_x,
  output logic [31:0] out_y,
  output logic [31:0] out_z,
  output logic [3:0]  segment_start,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import kvi_pkg::*;

  logic [31:0] time_table [MAX_KEYS];
  logic [31:0] x_table    [MAX_KEYS];
  logic [31:0] y_table    [MAX_KEYS];
  logic [31:0] z_table    [MAX_KEYS];
  logic        mode_table [MAX_KEYS];

  kvi_state_t state, state_next;
  logic [4:0] key_count;
  logic       in_accept;
  logic [31:0] t_reg;

  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] scan_idx;
  logic [MAX_KEYS-1:0] lane_ge;
  logic [KEY_W-1:0] last_idx, next_idx, last_scan, next_scan, rd_addr;

  logic [31:0] rd_time, rd_x, rd_y, rd_z;
  logic        rd_mode;
  logic [31:0] a_time, a_x, a_y, a_z, b_x, b_y, b_z;
  logic        a_mode;
  logic        need_div, div_done;
  logic [FRAC_W-1:0] quot, f;
  logic [33:0] ff;
  logic [50:0] fff;
  logic [51:0] three_ff, two_fff, num;
  logic [31:0] res_x, res_y, res_z;
  logic        out_load;

  assign pready    = 1'b1;
  assign in_accept = in_valid && !in_stall;
  assign prdata    = (paddr[2] == REG_KEY_COUNT) ? {27'b0, key_count} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= 5'd1;
    end else if (psel && penable && pwrite && paddr[2] == REG_KEY_COUNT) begin
      key_count <= pwdata[4:0];
    end
  end

  // Keyframe store: written by a write transfer, one registered read port.
  always_ff @(posedge clk) begin
    if (in_accept && command == CMD_WRITE) begin
      time_table[entry_index] <= key_time;
      x_table[entry_index]    <= key_value_x;
      y_table[entry_index]    <= key_value_y;
      z_table[entry_index]    <= key_value_z;
      mode_table[entry_index] <= interp_mode;
    end
    rd_time <= time_table[rd_addr];
    rd_x    <= x_table[rd_addr];
    rd_y    <= y_table[rd_addr];
    rd_z    <= z_table[rd_addr];
    rd_mode <= mode_table[rd_addr];
  end

  // Compare lanes, one per key, then the merge that finds the first later key.
  always_comb begin
    if (key_count == 5'd0) begin
      n_eff = CNT_W'(1);
    end else if (32'(key_count) > MAX_KEYS) begin
      n_eff = CNT_W'(MAX_KEYS);
    end else begin
      n_eff = CNT_W'(key_count);
    end
    for (int j = 0; j < MAX_KEYS; j++) begin
      lane_ge[j] = (CNT_W'(j) < n_eff) && (t_reg >= time_table[j]);
    end
    scan_idx = n_eff;
    for (int j = MAX_KEYS - 1; j >= 0; j--) begin
      if (!lane_ge[j]) scan_idx = CNT_W'(j);
    end
    last_scan = (scan_idx == '0) ? '0 : KEY_W'(scan_idx - CNT_W'(1));
    next_scan = (scan_idx == n_eff) ? KEY_W'(n_eff - CNT_W'(1)) : KEY_W'(scan_idx);
  end

  assign rd_addr  = (state == ST_RD_LAST) ? last_idx : next_idx;
  assign need_div = (last_idx != next_idx) && (rd_time > a_time);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (in_accept && command == CMD_EVAL) state_next = ST_SCAN;
      ST_SCAN:    state_next = ST_RD_LAST;
      ST_RD_LAST: state_next = ST_RD_NEXT;
      ST_RD_NEXT: state_next = ST_LOAD;
      ST_LOAD:    state_next = need_div ? ST_DIVIDE : (a_mode ? ST_SM1 : ST_BL1);
      ST_DIVIDE:  if (div_done) state_next = a_mode ? ST_SM1 : ST_BL1;
      ST_SM1:     state_next = ST_SM2;
      ST_SM2:     state_next = ST_SM3;
      ST_SM3:     state_next = ST_BL1;
      ST_BL1:     state_next = ST_BL2;
      ST_BL2:     state_next = ST_DONE;
      ST_DONE:    if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != ST_IDLE);
    out_load = (state == ST_DONE) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  assign three_ff = ({18'b0, ff} << 16) + ({18'b0, ff} << 17);
  assign two_fff  = {fff, 1'b0};
  assign num      = three_ff - two_fff;

  always_ff @(posedge clk) begin
    if (in_accept) t_reg <= sample_time;
    if (state == ST_SCAN) begin
      last_idx <= last_scan;
      next_idx <= next_scan;
    end
    if (state == ST_RD_NEXT) begin
      a_time <= rd_time;
      a_x    <= rd_x;
      a_y    <= rd_y;
      a_z    <= rd_z;
      a_mode <= rd_mode;
    end
    if (state == ST_LOAD) begin
      b_x <= rd_x;
      b_y <= rd_y;
      b_z <= rd_z;
      if (!need_div) f <= FRAC_ONE;
    end
    if (state == ST_DIVIDE && div_done) f <= quot;
    if (state == ST_SM1) ff  <= 34'(f) * 34'(f);
    if (state == ST_SM2) fff <= 51'(ff) * 51'(f);
    if (state == ST_SM3) f   <= num[48:32];
  end

  kvi_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_LOAD && need_div),
    .dividend (t_reg - a_time),
    .divisor  (rd_time - a_time),
    .done     (div_done),
    .quotient (quot)
  );

  kvi_blend_lane u_lane_x (.clk(clk), .a(a_x), .b(b_x), .f(f), .result(res_x));
  kvi_blend_lane u_lane_y (.clk(clk), .a(a_y), .b(b_y), .f(f), .result(res_y));
  kvi_blend_lane u_lane_z (.clk(clk), .a(a_z), .b(b_z), .f(f), .result(res_z));

  // Output register: holds a stalled result independently of the sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_x         <= res_x;
      out_y         <= res_y;
      out_z         <= res_z;
      segment_start <= 4'(last_idx);
    end
  end

  a_eval_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (in_accept && command == CMD_EVAL) |=> state == ST_SCAN)
    else $error("evaluate transfer did not start the scan");

  a_div_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIVIDE)
    else $error("divider finished outside the divide state");

  a_frac_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_BL1 |-> f <= FRAC_ONE)
    else $error("fraction above one at blend");

  a_load_only_done: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid)
    else $error("result load did not raise out_valid");

endmodule

### test/kvi_checker.sv
`timescale 1ns / 100ps
// Result checker for the keyframe vector interpolator: watches the input,
// configuration and output channels, predicts each result and compares it.
// Depends on kvi_pkg.
module kvi_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        command,
  input  logic [3:0]  entry_index,
  input  logic [31:0] key_time,
  input  logic [31:0] key_value_x,
  input  logic [31:0] key_value_y,
  input  logic [31:0] key_value_z,
  input  logic        interp_mode,
  input  logic [31:0] sample_time,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_x,
  input  logic [31:0] out_y,
  input  logic [31:0] out_z,
  input  logic [3:0]  segment_start,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);
  import kvi_pkg::*;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [3:0]  seg;
  } sample_t;

  logic [31:0] key_times [MAX_KEYS];
  logic [31:0] key_xs [MAX_KEYS];
  logic [31:0] key_ys [MAX_KEYS];
  logic [31:0] key_zs [MAX_KEYS];
  logic        key_modes [MAX_KEYS];
  logic [4:0]  active_keys;
  sample_t     expected_samples [$];

  assign pending = expected_samples.size();

  function automatic logic [31:0] lerp(logic [31:0] a, logic [31:0] b, logic [16:0] f);
    longint d;
    longint p;
    p = (longint'($signed(b)) - longint'($signed(a))) * longint'(f);
    // Floor division by 2^16, for negative products too.
    d = p >>> 16;
    return 32'(longint'($signed(a)) + d);
  endfunction

  function automatic sample_t interpolate(logic [31:0] t);
    int n, i, lo, hi;
    logic [63:0] q, ff, fff;
    logic [16:0] f;
    sample_t r;
    n = (active_keys == 0) ? 1 : (active_keys > MAX_KEYS ? MAX_KEYS : active_keys);
    i = 0;
    while (i < n && t >= key_times[i]) i++;
    hi = (i == n) ? n - 1 : i;
    lo = (i == 0) ? 0 : i - 1;
    f = FRAC_ONE;
    if (hi != lo && key_times[hi] > key_times[lo]) begin
      if (t >= key_times[lo]) begin
        q = {32'd0, t - key_times[lo]} << 16;
        q = q / {32'd0, key_times[hi] - key_times[lo]};
        f = (q > 65536) ? FRAC_ONE : 17'(q);
      end else begin
        f = '0;
      end
    end
    if (key_modes[lo]) begin
      ff = 64'(f) * 64'(f);
      fff = ff * 64'(f);
      f = 17'((3 * ff * 65536 - 2 * fff) >> 32);
    end
    r.x = lerp(key_xs[lo], key_xs[hi], f);
    r.y = lerp(key_ys[lo], key_ys[hi], f);
    r.z = lerp(key_zs[lo], key_zs[hi], f);
    r.seg = 4'(lo);
    return r;
  endfunction

  always @(posedge clk) begin
    sample_t e;
    if (rst) begin
      active_keys <= 5'd1;
      expected_samples.delete();
      fail_count <= 0;
      for (int k = 0; k < MAX_KEYS; k++) begin
        key_times[k] <= '0;
        key_xs[k] <= '0;
        key_ys[k] <= '0;
        key_zs[k] <= '0;
        key_modes[k] <= 1'b0;
      end
    end else begin
      if (psel && penable && pwrite && pready && paddr == 3'd0)
        active_keys <= pwdata[4:0];
      if (in_valid && !in_stall) begin
        if (command == CMD_WRITE) begin
          key_times[entry_index] <= key_time;
          key_xs[entry_index] <= key_value_x;
          key_ys[entry_index] <= key_value_y;
          key_zs[entry_index] <= key_value_z;
          key_modes[entry_index] <= interp_mode;
        end else begin
          expected_samples.push_back(interpolate(sample_time));
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected result x=%h y=%h z=%h seg=%0d",
                   $time, out_x, out_y, out_z, segment_start);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_samples.pop_front();
          if (e != {out_x, out_y, out_z, segment_start}) begin
            $display("%0t: mismatch expected x=%h y=%h z=%h seg=%0d", $time,
                     e.x, e.y, e.z, e.seg);
            $display("%0t:          actual   x=%h y=%h z=%h seg=%0d", $time,
                     out_x, out_y, out_z, segment_start);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

### test/tb_keyframe_vector_interpolator_core.sv
`timescale 1ns / 100ps
// Testbench top for the keyframe vector interpolator: clock, reset, directed
// and random keyframe and evaluate transfers, register writes and verdict.
// Depends on kvi_pkg, kvi_checker and the block under test.
module tb_keyframe_vector_interpolator_core;
  import kvi_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic command = CMD_WRITE;
  logic [3:0] entry_index = '0;
  logic [31:0] key_time = '0, key_value_x = '0, key_value_y = '0, key_value_z = '0;
  logic interp_mode = 1'b0;
  logic [31:0] sample_time = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] out_x, out_y, out_z;
  logic [3:0] segment_start;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int fail_count, pending;
  int quiet_cycles = 0;
  bit hold_off = 1'b0;
  bit hold_done = 1'b0;
  int keys_now = 1;
  logic [31:0] times_now [MAX_KEYS];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  keyframe_vector_interpolator_core u_top (.*);
  kvi_checker u_checker (.*);

  // Receiver: random stalls, one long hold-off when asked.
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (hold_off) out_stall <= 1'b1;
    else if ($urandom_range(0, 3) == 0) out_stall <= 1'b1;
    else if ($urandom_range(0, 40) == 0) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(0, 9) == 0) && out_stall;
  end

  initial begin
    wait (hold_off);
    repeat (600) @(posedge clk);
    hold_off = 1'b0;
    hold_done = 1'b1;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send(logic cmd, logic [3:0] idx, logic [31:0] t, logic [31:0] x,
                      logic [31:0] y, logic [31:0] z, logic m, logic [31:0] st);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
    if (gap > 0 && !hold_off) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    entry_index <= idx;
    key_time <= t;
    key_value_x <= x;
    key_value_y <= y;
    key_value_z <= z;
    interp_mode <= m;
    sample_time <= st;
    do @(posedge clk); while (in_stall);
    if (cmd == CMD_WRITE) times_now[idx] = t;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_keys(logic [31:0] v);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'd0; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
    keys_now = (v[4:0] == 0) ? 1 : (v[4:0] > MAX_KEYS ? MAX_KEYS : v[4:0]);
  endtask

  function automatic logic [31:0] rnd_value();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      default: return $urandom;
    endcase
  endfunction

  // Fills every slot with non-decreasing times from a base (zero when tight, else random) and random spacing.
  task automatic fill_table(bit tight);
    logic [31:0] t;
    logic [31:0] step;
    t = tight ? 32'd0 : $urandom_range(0, 32'h10_0000);
    for (int k = 0; k < MAX_KEYS; k++) begin
      step = tight ? $urandom_range(0, 3) : $urandom_range(0, 32'h0800_0000);
      if (k == MAX_KEYS - 1 && !tight) step = 32'hffff_ffff - t;
      else if (32'hffff_ffff - t < step) step = 0;
      t = t + ((k == 0) ? 32'd0 : step);
      send(CMD_WRITE, 4'(k), t, rnd_value(), rnd_value(), rnd_value(),
           1'($urandom), $urandom);
    end
  endtask

  function automatic logic [31:0] pick_time();
    int k;
    k = $urandom_range(0, keys_now - 1);
    case ($urandom_range(0, 5))
      0: return times_now[k];
      1: return times_now[k] - 1;
      2: return times_now[k] + 1;
      3: return (k + 1 < keys_now) ?
                times_now[k] + (times_now[k + 1] - times_now[k]) / 2 : $urandom;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: extremes of values and times, both modes, equal times.
    send(CMD_WRITE, 4'd0, 32'd100, 32'h8000_0000, 32'h7fff_ffff, 32'd0, 1'b1, 32'd0);
    send(CMD_WRITE, 4'd1, 32'd100, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 1'b0,
         32'd0);
    send(CMD_WRITE, 4'd2, 32'hffff_ffff, 32'h8000_0000, 32'd5, 32'd7, 1'b0, 32'd0);
    for (int k = 3; k < MAX_KEYS; k++)
      send(CMD_WRITE, 4'(k), 32'hffff_ffff, 32'(k), 32'(-k), 32'h1234_5678, 1'b1,
           32'd0);
    drain();
    set_keys(32'd0);
    send(CMD_EVAL, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 32'd0);
    send(CMD_EVAL, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 32'hffff_ffff);
    drain();
    set_keys(32'd3);
    send(CMD_EVAL, 4'hf, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
         1'b1, 32'd99);
    send(CMD_EVAL, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 32'd100);
    send(CMD_EVAL, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 32'h8000_0000);
    send(CMD_EVAL, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 32'hffff_ffff);
    drain();
    set_keys(32'd31);
    send(CMD_EVAL, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 32'hffff_fffe);
    send(CMD_EVAL, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 32'hffff_ffff);
    drain();
    // Random phases: refill the table, pick a key count, evaluate, with occasional writes past the key count.
    for (int ph = 0; ph < 12; ph++) begin
      fill_table(ph % 4 == 3);
      drain();
      set_keys((ph == 0) ? 32'd16 : (ph == 1) ? 32'd1 : (ph == 2) ? 32'd17 :
               $urandom_range(0, 31) | ($urandom & 32'hffff_ffe0));
      if (ph == 4) hold_off = 1'b1;
      for (int n = 0; n < 55; n++) begin
        if ($urandom_range(0, 9) == 0)
          send(CMD_WRITE, 4'($urandom_range(keys_now, 15)), $urandom, $urandom,
               $urandom, $urandom, 1'($urandom), $urandom);
        else
          send(CMD_EVAL, 4'($urandom), $urandom, $urandom, $urandom, $urandom,
               1'($urandom), pick_time());
      end
      drain();
    end
    wait (hold_done);
    drain();
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
